// ----- hdl/nbff_pkg.sv -----
// Shared types and constants for the navigation bit frame finder.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package nbff_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 10;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = CountW;

  localparam logic [ByteW-1:0]  PreambleReset  = 8'h8B;
  localparam logic [CountW-1:0] FrameBitsReset = 10'd300;
  localparam logic [CountW-1:0] PreambleBits   = 10'd8;

  typedef enum logic [KindW-1:0] {
    KindPreamble = 2'd0,
    KindData     = 2'd1,
    KindFinal    = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegPreamble  = 2'd0,
    RegFrameBits = 2'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

// ----- hdl/nbff_if.sv -----
// Channel interfaces of the navigation bit frame finder: bit input, result
// output and configuration write. Depends on nbff_pkg.
`default_nettype none

interface nbff_in_if;
  logic valid;
  logic ready;
  logic data_bit;

  modport source (output valid, output data_bit, input ready);
  modport sink   (input valid, input data_bit, output ready);
endinterface

interface nbff_out_if;
  logic                           valid;
  logic                           ready;
  logic [nbff_pkg::KindW-1:0]     kind;
  logic [nbff_pkg::ByteW-1:0]     byte_value;
  logic                           frame_end;

  modport source (output valid, output kind, output byte_value, output frame_end,
                  input ready);
  modport sink   (input valid, input kind, input byte_value, input frame_end,
                  output ready);
endinterface

interface nbff_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nbff_pkg::CfgIdxW-1:0]    index;
  logic [nbff_pkg::CfgDataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/nav_bit_frame_finder_top.sv -----
// Navigation bit frame finder top level: preamble search, byte assembly and
// frame end handling. Depends on nbff_pkg and the interfaces in nbff_if.sv.
//
// One data bit is taken per clock cycle. The shift register, frame counter
// and preamble compare update in the cycle a bit is accepted, and any result
// lands in a single output register at that same clock edge. Input ready drops only
// while that register holds a result the sink has not taken, so throughput
// is one bit per cycle whenever the sink keeps up. Configuration writes are
// always accepted; indexes past the frame length register are ignored.
`default_nettype none

module nav_bit_frame_finder_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  nbff_in_if.sink    in_ch,
  nbff_out_if.source out_ch,
  nbff_cfg_if.sink   cfg_ch
);

  logic [nbff_pkg::ByteW-1:0]  preamble_q;
  logic [nbff_pkg::CountW-1:0] frame_bits_q;

  logic [nbff_pkg::ByteW-1:0]  shift_q, shift_d;
  logic [nbff_pkg::CountW-1:0] count_q, count_d;
  logic                        in_frame_q, in_frame_d;

  logic                        out_valid_q;
  nbff_pkg::kind_e             kind_q, kind_d;
  logic [nbff_pkg::ByteW-1:0]  value_q, value_d;
  logic                        end_q, end_d;
  logic                        emit;

  logic                        in_acc;
  logic                        cfg_acc;
  logic [nbff_pkg::ByteW-1:0]  next_byte;
  logic [nbff_pkg::CountW-1:0] count_inc;
  logic [2:0]                  align;

  assign in_ch.ready  = !out_valid_q || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;

  assign next_byte = {shift_q[nbff_pkg::ByteW-2:0], in_ch.data_bit};
  assign count_inc = count_q + nbff_pkg::CountW'(1);
  // 8 - (len mod 8), which wraps to zero for a whole last byte
  assign align     = 3'd0 - frame_bits_q[2:0];

  always_comb begin
    shift_d    = shift_q;
    count_d    = count_q;
    in_frame_d = in_frame_q;
    emit       = 1'b0;
    kind_d     = nbff_pkg::KindData;
    value_d    = next_byte;
    end_d      = 1'b0;
    if (!in_frame_q) begin
      shift_d = next_byte;
      if (next_byte == preamble_q) begin
        in_frame_d = 1'b1;
        count_d    = nbff_pkg::PreambleBits;
        emit       = 1'b1;
        kind_d     = nbff_pkg::KindPreamble;
      end
    end else if (count_inc == frame_bits_q) begin
      in_frame_d = 1'b0;
      shift_d    = '0;
      count_d    = '0;
      emit       = 1'b1;
      kind_d     = nbff_pkg::KindFinal;
      value_d    = next_byte << align;
      end_d      = 1'b1;
    end else begin
      shift_d = next_byte;
      count_d = count_inc;
      emit    = (count_inc[2:0] == 3'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q   <= nbff_pkg::PreambleReset;
      frame_bits_q <= nbff_pkg::FrameBitsReset;
    end else if (cfg_acc) begin
      unique case (nbff_pkg::cfg_reg_e'(cfg_ch.index))
        nbff_pkg::RegPreamble:  preamble_q   <= cfg_ch.data[nbff_pkg::ByteW-1:0];
        nbff_pkg::RegFrameBits: frame_bits_q <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      count_q     <= '0;
      in_frame_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        shift_q    <= shift_d;
        count_q    <= count_d;
        in_frame_q <= in_frame_d;
      end
      if (in_ch.ready) begin
        out_valid_q <= in_acc && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      end_q   <= end_d;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.kind       = kind_q;
  assign out_ch.byte_value = value_q;
  assign out_ch.frame_end  = end_q;

  // frame end only ever rides on the final byte
  a_end_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && end_q |-> kind_q == nbff_pkg::KindFinal)
    else $error("frame end on non-final result");

  // preamble match while searching enters the frame with the count at 8
  a_sync_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_frame_q && next_byte == preamble_q
    |=> in_frame_q && count_q == nbff_pkg::PreambleBits && out_valid_q
        && kind_q == nbff_pkg::KindPreamble)
    else $error("preamble match did not enter frame");

  // leaving the frame always posts the final result and clears the state
  a_frame_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_frame_q) |-> out_valid_q && end_q && count_q == '0 && shift_q == '0)
    else $error("frame left without final result");

  // a stalled result is never overwritten by a new bit
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.ready |-> !in_acc)
    else $error("bit accepted while result stalled");

endmodule

`default_nettype wire

// ----- verif/tb_nav_bit_frame_finder_top.sv -----
// Testbench for nav_bit_frame_finder_top: drives data bits, configures the
// preamble and frame length, and checks each report against its own predictor.
// Depends on nbff_pkg, the channel interfaces in nbff_if.sv and the top level.
`default_nettype none

module tb_nav_bit_frame_finder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned RandomBits = 600;
  localparam logic [nbff_pkg::CfgIdxW-1:0] UnusedRegIdx = 2'd3;

  typedef struct packed {
    nbff_pkg::kind_e            kind;
    logic [nbff_pkg::ByteW-1:0] byte_value;
    logic                       frame_end;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  nbff_in_if  bit_ch ();
  nbff_out_if report_ch ();
  nbff_cfg_if reg_ch ();

  nav_bit_frame_finder_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (bit_ch),
    .out_ch (report_ch),
    .cfg_ch (reg_ch)
  );

  always #5 clk_i = ~clk_i;

  // frame sync predictor state and its copy of the registers
  logic [nbff_pkg::ByteW-1:0]  sync_shift  = '0;
  logic [nbff_pkg::CountW-1:0] frame_count = '0;
  logic                        locked      = 1'b0;
  logic [nbff_pkg::ByteW-1:0]  want_pattern   = nbff_pkg::PreambleReset;
  logic [nbff_pkg::CountW-1:0] want_frame_len = nbff_pkg::FrameBitsReset;

  logic    nav_bits[$];
  report_t owed_reports[$];
  int      bits_queued  = 0;
  int      bits_taken   = 0;
  int      reports_seen = 0;
  int      fault_count  = 0;
  int      quiet_cycles = 0;
  int      send_gap     = 0;
  int      recv_hold    = 0;
  bit      long_hold_done = 1'b0;
  bit      calm = 1'b0;

  task automatic advance_frame_sync(input logic b);
    logic [nbff_pkg::ByteW-1:0] nxt;
    logic [2:0]                 rem;
    report_t                    r;
    nxt = {sync_shift[nbff_pkg::ByteW-2:0], b};
    if (!locked) begin
      sync_shift = nxt;
      if (nxt == want_pattern) begin
        locked      = 1'b1;
        frame_count = nbff_pkg::PreambleBits;
        r.kind = nbff_pkg::KindPreamble; r.byte_value = nxt; r.frame_end = 1'b0;
        owed_reports.push_back(r);
      end
    end else begin
      frame_count = frame_count + 1'b1;
      if (frame_count == want_frame_len) begin
        // leftover bits go to the top of the byte
        rem = want_frame_len[2:0];
        r.kind       = nbff_pkg::KindFinal;
        r.byte_value = (rem == 3'd0) ? nxt : nbff_pkg::ByteW'(nxt << (8 - rem));
        r.frame_end  = 1'b1;
        owed_reports.push_back(r);
        locked      = 1'b0;
        sync_shift  = '0;
        frame_count = '0;
      end else begin
        sync_shift = nxt;
        if (frame_count[2:0] == 3'd0) begin
          r.kind = nbff_pkg::KindData; r.byte_value = nxt; r.frame_end = 1'b0;
          owed_reports.push_back(r);
        end
      end
    end
  endtask

  task automatic check_report();
    report_t want;
    reports_seen++;
    if (owed_reports.size() == 0) begin
      $error("report with nothing owed: kind %0d byte %02h end %0d",
             report_ch.kind, report_ch.byte_value, report_ch.frame_end);
      fault_count++;
    end else begin
      want = owed_reports.pop_front();
      if (report_ch.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, report_ch.kind);
        fault_count++;
      end
      if (report_ch.byte_value !== want.byte_value) begin
        $error("byte_value: expected %02h, got %02h", want.byte_value,
               report_ch.byte_value);
        fault_count++;
      end
      if (report_ch.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end,
               report_ch.frame_end);
        fault_count++;
      end
    end
  endtask

  function automatic void push_bit(input logic b);
    nav_bits.push_back(b);
    bits_queued++;
  endfunction

  function automatic void push_byte(input logic [nbff_pkg::ByteW-1:0] v);
    for (int i = nbff_pkg::ByteW - 1; i >= 0; i--) push_bit(v[i]);
  endfunction

  function automatic void push_random(input int n);
    repeat (n) push_bit($urandom_range(0, 1) == 1);
  endfunction

  // noise, preamble, frame body; a broken frame has a randomly shortened body
  // and may have a damaged preamble
  function automatic void queue_frame(input logic [nbff_pkg::ByteW-1:0] pat,
                                      input int len, input bit broken);
    logic [nbff_pkg::ByteW-1:0] p;
    int                         body;
    p    = pat;
    body = len - 8;
    push_random($urandom_range(0, 6));
    if (broken && $urandom_range(0, 1) == 1) p[$urandom_range(0, nbff_pkg::ByteW - 1)] ^= 1'b1;
    if (broken) body = $urandom_range(0, len - 8);
    push_byte(p);
    push_random(body);
  endfunction

  task automatic write_reg(input logic [nbff_pkg::CfgIdxW-1:0] idx,
                           input logic [nbff_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= val;
    do @(posedge clk_i); while (!(reg_ch.valid && reg_ch.ready));
    case (idx)
      nbff_pkg::RegPreamble:  want_pattern   = val[nbff_pkg::ByteW-1:0];
      nbff_pkg::RegFrameBits: want_frame_len = val;
      default: ;
    endcase
    reg_ch.valid <= 1'b0;
  endtask

  // all queued bits taken and all reports in, then let the pipeline settle
  task automatic drain();
    while (bits_taken != bits_queued || owed_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // bit request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ch.valid    <= 1'b0;
      bit_ch.data_bit <= 1'b0;
      send_gap = 0;
    end else begin
      if (bit_ch.valid && bit_ch.ready) begin
        advance_frame_sync(bit_ch.data_bit);
        bits_taken++;
      end
      if (!(bit_ch.valid && !bit_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          bit_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
          send_gap = $urandom_range(0, 8);
          bit_ch.valid <= 1'b0;
        end else if (nav_bits.size() != 0) begin
          bit_ch.valid    <= 1'b1;
          bit_ch.data_bit <= nav_bits.pop_front();
        end else begin
          bit_ch.valid <= 1'b0;
        end
      end
    end
  end

  // report monitor and sink stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_ch.ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (report_ch.valid && report_ch.ready) check_report();
      if (!long_hold_done && reports_seen >= 10) begin
        // long stall so the output register fills and input ready drops
        long_hold_done = 1'b1;
        recv_hold = LongHold;
        report_ch.ready <= 1'b0;
      end else if (recv_hold > 0) begin
        recv_hold--;
        report_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        recv_hold = $urandom_range(0, 8);
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (bit_ch.valid && bit_ch.ready) || (report_ch.valid && report_ch.ready)
        || (reg_ch.valid && reg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                         random_start;
    int                         phase_start;
    int                         frame_len;
    logic [nbff_pkg::ByteW-1:0] pattern;

    rst_ni          = 1'b0;
    bit_ch.valid    = 1'b0;
    bit_ch.data_bit = 1'b0;
    report_ch.ready = 1'b0;
    reg_ch.valid    = 1'b0;
    reg_ch.index    = nbff_pkg::RegPreamble;
    reg_ch.data     = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register reset values: default preamble, 300-bit frame
    queue_frame(nbff_pkg::PreambleReset, nbff_pkg::FrameBitsReset, 1'b0);
    drain();

    // all-ones preamble seen again inside a 16-bit frame; last byte is full
    write_reg(nbff_pkg::RegPreamble, nbff_pkg::CfgDataW'(8'hFF));
    write_reg(nbff_pkg::RegFrameBits, nbff_pkg::CfgDataW'(16));
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h00);
    drain();

    // all-zeros preamble, one leftover bit, plus a write to an unused index
    write_reg(nbff_pkg::RegPreamble, nbff_pkg::CfgDataW'(8'h00));
    write_reg(nbff_pkg::RegFrameBits, nbff_pkg::CfgDataW'(17));
    write_reg(UnusedRegIdx, nbff_pkg::CfgDataW'(10'h3FF));
    queue_frame(8'h00, 17, 1'b0);
    drain();

    // frame shorter than the preamble: counter wraps before frame end
    write_reg(nbff_pkg::RegPreamble, nbff_pkg::CfgDataW'(8'hA5));
    write_reg(nbff_pkg::RegFrameBits, nbff_pkg::CfgDataW'(4));
    push_byte(8'hA5);
    push_random(1020);
    drain();

    random_start = bits_queued;
    while (bits_queued - random_start < RandomBits) begin
      calm = (bits_queued - random_start >= RandomBits - 400);
      pattern   = $urandom_range(0, 255);
      frame_len = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 400)
                                              : $urandom_range(16, 40);
      write_reg(nbff_pkg::RegPreamble, nbff_pkg::CfgDataW'(pattern));
      write_reg(nbff_pkg::RegFrameBits, nbff_pkg::CfgDataW'(frame_len));
      phase_start = bits_queued;
      while (bits_queued - phase_start < 200)
        queue_frame(pattern, frame_len, $urandom_range(0, 7) == 0);
      drain();
    end

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/nbff_pkg.sv
hdl/nbff_if.sv
hdl/nav_bit_frame_finder_top.sv
verif/tb_nav_bit_frame_finder_top.sv
